>>> rtl/core/sector_cache_lru_directory_top_assert.svh
// ---------------------------------------------------------------------------
// sector cache lru directory assertion macros
// property shorthands used by the port checker
// ---------------------------------------------------------------------------
`ifndef SECTOR_CACHE_LRU_DIRECTORY_TOP_ASSERT_SVH
`define SECTOR_CACHE_LRU_DIRECTORY_TOP_ASSERT_SVH

// next-cycle implication, quiet while in reset
`define SCLD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scld port check failed");

// next-cycle implication that also covers reset itself
`define SCLD_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("scld reset check failed");

`endif

>>> rtl/core/scld_pkg.sv
// ---------------------------------------------------------------------------
// scld_pkg
// shared types and constants of the sector cache lru directory
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scld_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int SLOT_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int TAG_W       = 31;
    localparam int STAMP_W     = 32;
    localparam int ACTION_W    = 2;
    localparam int CFG_W       = 7;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TOUCH  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // partial scan result handed from cell to cell
    typedef struct packed {
        logic               vld;
        logic               hit;
        logic [SLOT_W-1:0]  hit_idx;
        logic               has_best;
        logic [STAMP_W-1:0] best_stamp;
        logic [SLOT_W-1:0]  best_idx;
    } t_carry;

    // write broadcast from the control to all cells
    typedef struct packed {
        logic               tag_en;
        logic               stamp_en;
        logic [SLOT_W-1:0]  idx;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } t_wr;

endpackage

`default_nettype wire

>>> rtl/core/scld_cell.sv
// ---------------------------------------------------------------------------
// scld_cell
// one directory slot: holds tag and stamp, folds itself into the passing scan
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scld_cell (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire        [scld_pkg::SLOT_W-1:0]   i_idx,
    input  wire        [scld_pkg::CNT_W-1:0]    i_filled_count,
    input  wire        [scld_pkg::TAG_W-1:0]    i_sector,
    input  scld_pkg::t_wr                       i_wr,
    input  scld_pkg::t_carry                    i_carry,
    output scld_pkg::t_carry                    o_carry
);

    logic [scld_pkg::TAG_W-1:0]   r_tag;
    logic [scld_pkg::STAMP_W-1:0] r_stamp;
    scld_pkg::t_carry             r_carry;
    scld_pkg::t_carry             n_carry;
    logic                         filled;

    assign filled = (scld_pkg::CNT_W'(i_idx) < i_filled_count);

    always_comb begin
        n_carry = i_carry;
        if (i_carry.vld && filled) begin
            // first match wins, so a later cell leaves an earlier hit alone
            if (!i_carry.hit && (r_tag == i_sector)) begin
                n_carry.hit     = 1'b1;
                n_carry.hit_idx = i_idx;
            end
            // strict compare keeps the lowest index on equal stamps
            if (!i_carry.has_best || (r_stamp < i_carry.best_stamp)) begin
                n_carry.has_best   = 1'b1;
                n_carry.best_stamp = r_stamp;
                n_carry.best_idx   = i_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry <= '0;
        end else begin
            r_carry <= n_carry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.tag_en && (i_wr.idx == i_idx)) begin
            r_tag <= i_wr.tag;
        end
        if (i_wr.stamp_en && (i_wr.idx == i_idx)) begin
            r_stamp <= i_wr.stamp;
        end
    end

    assign o_carry = r_carry;

endmodule

`default_nettype wire

>>> rtl/core/sector_cache_lru_directory_top.sv
// ---------------------------------------------------------------------------
// sector_cache_lru_directory_top
// fully associative sector tag directory with lru replacement by stamps
// ---------------------------------------------------------------------------
//  channel  | direction | handshake                 | word
//  ---------+-----------+---------------------------+-----------------------------
//  item in  | in        | i_valid / o_stall         | i_action i_sector i_slot_in
//  result   | out       | o_valid / i_stall         | o_hit o_slot_out o_replaced
//  config   | in        | i_cfg_valid / o_cfg_ready | i_entries_in_use
//
//  lookup and a replacing insert run one scan down the 64-cell chain: the item
//  passes r_start and the cell registers, then the scan result registers
//  a filling insert, a touch or an unknown action go from accept straight to
//  ST_DONE; ST_DONE loads the result into the output register once it is free
//  one item at a time; o_stall stays high until the result is in the output
//  register, which holds while i_stall is high
//  synchronous active-low reset clears counts and the output; slots come up
//  empty, tags and stamps need no clearing
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sector_cache_lru_directory_top (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire        [scld_pkg::ACTION_W-1:0] i_action,
    input  wire        [scld_pkg::TAG_W-1:0]    i_sector,
    input  wire        [scld_pkg::SLOT_W-1:0]   i_slot_in,
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic                                o_hit,
    output logic       [scld_pkg::SLOT_W-1:0]   o_slot_out,
    output logic                                o_replaced,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire        [scld_pkg::CFG_W-1:0]    i_entries_in_use
);

    scld_pkg::t_state              r_state;
    scld_pkg::t_state              n_state;
    logic [scld_pkg::CFG_W-1:0]    r_entries_in_use;
    logic [scld_pkg::CNT_W-1:0]    r_filled_count;
    logic [scld_pkg::CNT_W-1:0]    n_filled_count;
    logic [scld_pkg::STAMP_W-1:0]  r_access_counter;
    logic [scld_pkg::STAMP_W-1:0]  n_access_counter;
    logic [scld_pkg::ACTION_W-1:0] r_action;
    logic [scld_pkg::TAG_W-1:0]    r_sector;
    logic [scld_pkg::SLOT_W-1:0]   r_slot_in;
    logic                          r_start;
    logic                          r_scan_hit;
    logic [scld_pkg::SLOT_W-1:0]   r_scan_hit_idx;
    logic [scld_pkg::SLOT_W-1:0]   r_scan_best_idx;
    logic                          r_out_valid;
    logic                          r_hit;
    logic [scld_pkg::SLOT_W-1:0]   r_slot_out;
    logic                          r_replaced;

    logic [scld_pkg::CNT_W-1:0]    limit;
    logic                          full;
    logic                          in_acc;
    logic                          need_scan;
    logic                          out_free;
    logic                          fire;
    logic                          res_hit;
    logic [scld_pkg::SLOT_W-1:0]   res_slot;
    logic                          res_replaced;
    logic [scld_pkg::STAMP_W-1:0]  cnt_inc;
    scld_pkg::t_wr                 w_wr;
    scld_pkg::t_carry              w_carry [0:scld_pkg::MAX_ENTRIES];

    // slot limit: zero acts as one, anything above the cell count saturates
    always_comb begin
        if (r_entries_in_use == '0) begin
            limit = scld_pkg::CNT_W'(1);
        end else if (int'(r_entries_in_use) > scld_pkg::MAX_ENTRIES) begin
            limit = scld_pkg::CNT_W'(scld_pkg::MAX_ENTRIES);
        end else begin
            limit = scld_pkg::CNT_W'(r_entries_in_use);
        end
    end

    assign full      = (r_filled_count >= limit);
    assign in_acc    = i_valid && !o_stall;
    assign need_scan = (i_action == scld_pkg::ACT_LOOKUP) ||
                       ((i_action == scld_pkg::ACT_INSERT) && full);
    assign out_free  = !r_out_valid || !i_stall;
    assign fire      = (r_state == scld_pkg::ST_DONE) && out_free;
    assign cnt_inc   = r_access_counter + scld_pkg::STAMP_W'(1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            scld_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = need_scan ? scld_pkg::ST_SCAN : scld_pkg::ST_DONE;
                end
            end
            scld_pkg::ST_SCAN: begin
                if (w_carry[scld_pkg::MAX_ENTRIES].vld) begin
                    n_state = scld_pkg::ST_DONE;
                end
            end
            scld_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = scld_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = scld_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_stall = 1'b1;
        case (r_state)
            scld_pkg::ST_IDLE: o_stall = 1'b0;
            scld_pkg::ST_SCAN: o_stall = 1'b1;
            scld_pkg::ST_DONE: o_stall = 1'b1;
            default:           o_stall = 1'b1;
        endcase
    end

    // result and state update of the finished item
    always_comb begin
        res_hit          = 1'b0;
        res_slot         = '0;
        res_replaced     = 1'b0;
        n_filled_count   = r_filled_count;
        n_access_counter = r_access_counter;
        w_wr.tag_en      = 1'b0;
        w_wr.stamp_en    = 1'b0;
        w_wr.idx         = '0;
        w_wr.tag         = r_sector;
        w_wr.stamp       = cnt_inc;
        case (r_action)
            scld_pkg::ACT_LOOKUP: begin
                res_hit  = r_scan_hit;
                res_slot = r_scan_hit ? r_scan_hit_idx : '0;
            end
            scld_pkg::ACT_INSERT: begin
                n_access_counter = cnt_inc;
                w_wr.tag_en      = 1'b1;
                w_wr.stamp_en    = 1'b1;
                if (full) begin
                    w_wr.idx     = r_scan_best_idx;
                    res_replaced = 1'b1;
                end else begin
                    w_wr.idx       = r_filled_count[scld_pkg::SLOT_W-1:0];
                    n_filled_count = r_filled_count + scld_pkg::CNT_W'(1);
                end
                res_slot = w_wr.idx;
            end
            scld_pkg::ACT_TOUCH: begin
                n_access_counter = cnt_inc;
                w_wr.idx         = r_slot_in;
                // unfilled slot: counter moves, stamp stays
                w_wr.stamp_en    = (scld_pkg::CNT_W'(r_slot_in) < r_filled_count);
                res_slot         = r_slot_in;
            end
            default: begin
                res_slot = '0;
            end
        endcase
        if (!fire) begin
            n_filled_count   = r_filled_count;
            n_access_counter = r_access_counter;
            w_wr.tag_en      = 1'b0;
            w_wr.stamp_en    = 1'b0;
        end
    end

    always_comb begin
        w_carry[0].vld        = r_start;
        w_carry[0].hit        = 1'b0;
        w_carry[0].hit_idx    = '0;
        w_carry[0].has_best   = 1'b0;
        w_carry[0].best_stamp = '0;
        w_carry[0].best_idx   = '0;
    end

    for (genvar g = 0; g < scld_pkg::MAX_ENTRIES; g++) begin : g_cell
        scld_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_idx          (scld_pkg::SLOT_W'(g)),
            .i_filled_count (r_filled_count),
            .i_sector       (r_sector),
            .i_wr           (w_wr),
            .i_carry        (w_carry[g]),
            .o_carry        (w_carry[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= scld_pkg::ST_IDLE;
            r_entries_in_use <= scld_pkg::CFG_RESET;
            r_filled_count   <= '0;
            r_access_counter <= '0;
            r_start          <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state          <= n_state;
            r_filled_count   <= n_filled_count;
            r_access_counter <= n_access_counter;
            r_start          <= in_acc && need_scan;
            if (i_cfg_valid && o_cfg_ready) begin
                r_entries_in_use <= i_entries_in_use;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_action  <= i_action;
            r_sector  <= i_sector;
            r_slot_in <= i_slot_in;
        end
        if ((r_state == scld_pkg::ST_SCAN) && w_carry[scld_pkg::MAX_ENTRIES].vld) begin
            r_scan_hit      <= w_carry[scld_pkg::MAX_ENTRIES].hit;
            r_scan_hit_idx  <= w_carry[scld_pkg::MAX_ENTRIES].hit_idx;
            r_scan_best_idx <= w_carry[scld_pkg::MAX_ENTRIES].best_idx;
        end
        if (fire) begin
            r_hit      <= res_hit;
            r_slot_out <= res_slot;
            r_replaced <= res_replaced;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_hit       = r_hit;
    assign o_slot_out  = r_slot_out;
    assign o_replaced  = r_replaced;

endmodule

`default_nettype wire

>>> rtl/core/scld_checker.sv
// ---------------------------------------------------------------------------
// scld_checker
// port-level checks on the sector cache lru directory, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sector_cache_lru_directory_top_assert.svh"

module scld_checker (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    input  wire                                 o_stall,
    input  wire                                 o_valid,
    input  wire                                 i_stall,
    input  wire                                 o_hit,
    input  wire        [scld_pkg::SLOT_W-1:0]   o_slot_out,
    input  wire                                 o_replaced
);

    // a held result word keeps its valid
    `SCLD_ASSERT_NEXT(a_out_valid_hold, o_valid && i_stall, o_valid)

    // a held result word keeps its payload
    `SCLD_ASSERT_NEXT(a_out_word_hold, o_valid && i_stall, $stable(o_slot_out) && $stable(o_hit) && $stable(o_replaced))

    // an accepted item raises the input stall
    `SCLD_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall)

    // reset leaves no result on the output
    `SCLD_ASSERT_NEXT_ALWAYS(a_reset_clears_out, !i_rst_n, !o_valid)

endmodule

bind sector_cache_lru_directory_top scld_checker u_scld_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_hit      (o_hit),
    .o_slot_out (o_slot_out),
    .o_replaced (o_replaced)
);

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// The bench drives lookups, inserts, touches and unknown actions into the
// sector tag directory across a series of slot-count settings. An lru
// scoreboard predicts every result word and checks each one against the
// block's output. The sender and the receiver both idle at random.
// ---------------------------------------------------------------------------

module tb_top;

    import scld_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int N_PHASES    = 11;
    localparam int PHASE_ITEMS = 150;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              replaced;
    } t_dir_result;

    // lru directory scoreboard: own copy of tags, stamps and counters
    class lru_scoreboard;
        bit [TAG_W-1:0]   tag_mem   [MAX_ENTRIES];
        bit [STAMP_W-1:0] stamp_mem [MAX_ENTRIES];
        int unsigned      filled;
        bit [STAMP_W-1:0] access_cnt;
        bit [CFG_W-1:0]   slot_limit;
        t_dir_result      expected_q [$];
        int               errors;
        int               n_items, n_hits, n_misses, n_replaced, n_touches;

        function new();
            filled     = 0;
            access_cnt = '0;
            slot_limit = CFG_RESET;
            errors     = 0;
            n_items    = 0;
            n_hits     = 0;
            n_misses   = 0;
            n_replaced = 0;
            n_touches  = 0;
        endfunction

        function void set_limit(bit [CFG_W-1:0] value);
            slot_limit = value;
        endfunction

        function int unsigned usable_slots();
            if (slot_limit == 0) return 1;
            if (slot_limit > MAX_ENTRIES) return MAX_ENTRIES;
            return slot_limit;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // predicts the result word of one accepted item and queues it
        function void note_item(logic [ACTION_W-1:0] act, logic [TAG_W-1:0] sector,
                                logic [SLOT_W-1:0] slot_in);
            t_dir_result res;
            int unsigned victim;
            res = '0;
            n_items++;
            case (act)
                ACT_LOOKUP: begin
                    for (int i = 0; i < filled; i++) begin
                        if (tag_mem[i] == sector) begin
                            res.hit  = 1'b1;
                            res.slot = SLOT_W'(i);
                            break;
                        end
                    end
                    if (res.hit) n_hits++;
                    else n_misses++;
                end
                ACT_INSERT: begin
                    access_cnt++;
                    if (filled < usable_slots()) begin
                        victim = filled;
                        filled++;
                    end else begin
                        // oldest stamp among filled slots, lowest index on ties
                        victim = 0;
                        for (int i = 1; i < filled; i++) begin
                            if (stamp_mem[i] < stamp_mem[victim]) victim = i;
                        end
                        res.replaced = 1'b1;
                        n_replaced++;
                    end
                    tag_mem[victim]   = sector;
                    stamp_mem[victim] = access_cnt;
                    res.slot          = SLOT_W'(victim);
                end
                ACT_TOUCH: begin
                    access_cnt++;
                    if (slot_in < filled) stamp_mem[slot_in] = access_cnt;
                    res.slot = slot_in;
                    n_touches++;
                end
                default: ;
            endcase
            expected_q.push_back(res);
        endfunction

        function void check_result(logic hit, logic [SLOT_W-1:0] slot, logic replaced);
            t_dir_result exp_res;
            if (expected_q.size() == 0) begin
                $error("result word with no item pending: hit %0d slot %0d replaced %0d",
                       hit, slot, replaced);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (hit !== exp_res.hit) begin
                $error("hit: expected %0d, got %0d", exp_res.hit, hit);
                errors++;
            end
            if (slot !== exp_res.slot) begin
                $error("slot_out: expected %0d, got %0d", exp_res.slot, slot);
                errors++;
            end
            if (replaced !== exp_res.replaced) begin
                $error("replaced: expected %0d, got %0d", exp_res.replaced, replaced);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [ACTION_W-1:0] i_action;
    logic [TAG_W-1:0]    i_sector;
    logic [SLOT_W-1:0]   i_slot_in;
    logic                o_valid;
    logic                i_stall;
    logic                o_hit;
    logic [SLOT_W-1:0]   o_slot_out;
    logic                o_replaced;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_entries_in_use;

    lru_scoreboard sb;
    int            cycle_cnt = 0;
    int            stall_left = 0;
    logic          stall_lvl = 1'b0;
    int            burst_left = 0;
    bit            gaps_on = 1'b1;
    int            n_settings = 0;

    sector_cache_lru_directory_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_action         (i_action),
        .i_sector         (i_sector),
        .i_slot_in        (i_slot_in),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_hit            (o_hit),
        .o_slot_out       (o_slot_out),
        .o_replaced       (o_replaced),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_entries_in_use (i_entries_in_use)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver stall pattern: rotates through free, light, bursty and heavy
    always @(posedge i_clk) begin
        case ((cycle_cnt >> 11) & 3)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: begin
                if (stall_left == 0) begin
                    stall_left = $urandom_range(1, 30);
                    stall_lvl  = ~stall_lvl;
                end
                stall_left--;
                i_stall <= stall_lvl;
            end
            default: i_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_hit, o_slot_out, o_replaced);
    end

    // holds the word until the block takes it; valid stays high on return
    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [TAG_W-1:0] sector,
                             input logic [SLOT_W-1:0] slot_in);
        i_valid   <= 1'b1;
        i_action  <= act;
        i_sector  <= sector;
        i_slot_in <= slot_in;
        do @(posedge i_clk); while (o_stall);
        sb.note_item(act, sector, slot_in);
    endtask

    task automatic wait_all_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] value);
        wait_all_results();
        i_cfg_valid      <= 1'b1;
        i_entries_in_use <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_limit(value);
        n_settings++;
    endtask

    // one random item, mostly drawn from a small set of live sectors
    task automatic send_random(input logic [TAG_W-1:0] live [48], input int n_live);
        int r;
        logic [SLOT_W-1:0] slot_pick;
        r = $urandom_range(0, 99);
        if (sb.filled > 0) slot_pick = SLOT_W'($urandom_range(0, sb.filled - 1));
        else slot_pick = SLOT_W'($urandom);
        if (r < 40)
            send_item(ACT_LOOKUP, live[$urandom_range(0, n_live - 1)], SLOT_W'($urandom));
        else if (r < 65)
            send_item(ACT_INSERT, live[$urandom_range(0, n_live - 1)], SLOT_W'($urandom));
        else if (r < 85)
            send_item(ACT_TOUCH, TAG_W'($urandom), slot_pick);
        else if (r < 92)
            send_item(ACT_LOOKUP, TAG_W'($urandom), SLOT_W'($urandom));
        else if (r < 96)
            send_item(ACT_TOUCH, TAG_W'($urandom), SLOT_W'($urandom));
        else
            send_item(ACT_UNKNOWN, TAG_W'($urandom), SLOT_W'($urandom));
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] limit_val);
        logic [TAG_W-1:0] live [48];
        int n_live;
        write_limit(limit_val);
        n_live = $urandom_range(2, 48);
        for (int i = 0; i < 48; i++) live[i] = TAG_W'($urandom);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_random(live, n_live);
            if (gaps_on) begin
                if (burst_left == 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge i_clk);
                    burst_left = $urandom_range(1, 16);
                end else begin
                    burst_left--;
                end
            end
        end
    endtask

    initial begin
        logic [CFG_W-1:0] phase_limits [N_PHASES];
        phase_limits = '{7'd12, 7'd4, 7'd30, 7'd1, 7'd64, 7'd0, 7'd40, 7'd127, 7'd2,
                         7'd0, 7'd0};
        sb = new();
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_action         <= ACT_LOOKUP;
        i_sector         <= '0;
        i_slot_in        <= '0;
        i_stall          <= 1'b0;
        i_cfg_valid      <= 1'b0;
        i_entries_in_use <= CFG_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty directory: miss, touch of an unfilled slot, unknown action
        send_item(ACT_LOOKUP, '0, '0);
        send_item(ACT_TOUCH, '0, 6'd63);
        send_item(ACT_UNKNOWN, '1, '1);

        // zero limit acts as one slot
        write_limit(7'd0);
        send_item(ACT_INSERT, 31'h7FFF_FFFF, '0);
        send_item(ACT_INSERT, 31'h0, '0);
        send_item(ACT_LOOKUP, 31'h0, '0);
        send_item(ACT_LOOKUP, 31'h7FFF_FFFF, '0);

        // fill up, then a touch moves the victim away from slot 0
        write_limit(7'd3);
        send_item(ACT_INSERT, 31'h2AAA_AAAA, '0);
        send_item(ACT_INSERT, 31'h5555_5555, '0);
        send_item(ACT_TOUCH, '0, 6'd0);
        send_item(ACT_INSERT, 31'h1, '0);
        send_item(ACT_LOOKUP, 31'h5555_5555, '0);

        // limit below the filled count: counts as full
        write_limit(7'd2);
        send_item(ACT_INSERT, 31'h2, '0);
        send_item(ACT_TOUCH, '0, 6'd5);

        // limit above the slot count saturates, filling resumes
        write_limit(7'd127);
        send_item(ACT_INSERT, 31'h3, '0);
        send_item(ACT_LOOKUP, 31'h3, '0);
        send_item(ACT_TOUCH, '0, 6'd3);
        send_item(ACT_LOOKUP, 31'h4000_0000, '0);
        write_limit(7'd65);
        send_item(ACT_INSERT, 31'h4000_0000, '0);
        send_item(ACT_LOOKUP, 31'h4000_0000, '0);

        for (int p = 0; p < N_PHASES; p++) begin
            gaps_on = (p % 4 != 3);
            if (p >= N_PHASES - 2) phase_limits[p] = CFG_W'($urandom_range(0, 127));
            run_phase(phase_limits[p]);
        end

        wait_all_results();
        repeat (80) @(posedge i_clk);

        $display("covered %0d items over %0d slot-count settings: %0d hits, %0d misses,",
                 sb.n_items, n_settings, sb.n_hits, sb.n_misses);
        $display("%0d replacing inserts, %0d touches", sb.n_replaced, sb.n_touches);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            if (sb.pending() != 0) $error("%0d result words never arrived", sb.pending());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
